// ===== rtl/qbb_pkg.sv =====
// shared constants and types for the quadratic bezier bounding box block
// no dependencies; used by every other file of the block

package qbb_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int T_FRAC_BITS  = 16;

   localparam int A_WIDTH      = COORD_WIDTH + 2;
   localparam int TQ_WIDTH     = T_FRAC_BITS + 1;
   localparam int INNER_WIDTH  = A_WIDTH + T_FRAC_BITS + 2;
   localparam int SPLIT_LO     = INNER_WIDTH / 2;
   localparam int SPLIT_HI     = INNER_WIDTH - SPLIT_LO;
   localparam int PROD_WIDTH   = INNER_WIDTH + TQ_WIDTH;
   localparam int LANE_LATENCY = T_FRAC_BITS + 7;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] mn;
      logic signed [COORD_WIDTH-1:0] mx;
   } span_type;

endpackage

// ===== rtl/qbb_if.sv =====
// valid/ready channel interfaces for curve requests and box responses
// depends on qbb_pkg

interface qbb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] p0_x;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] p0_y;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] p1_x;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] p1_y;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] p2_x;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] p2_y;

   modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, input ready);
   modport sink   (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, output ready);
endinterface

interface qbb_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] box_min_x;
   logic signed [qbb_pkg::COORD_WIDTH-1:0] box_min_y;
   logic        [qbb_pkg::COORD_WIDTH-1:0] box_width;
   logic        [qbb_pkg::COORD_WIDTH-1:0] box_height;

   modport source (output valid, box_min_x, box_min_y, box_width, box_height, input ready);
   modport sink   (input valid, box_min_x, box_min_y, box_width, box_height, output ready);
endinterface

// ===== rtl/qbb_axis_lane.sv =====
// one axis lane: extremum test, pipelined restoring divider for t,
// curve evaluation at t and span update; depends on qbb_pkg

module qbb_axis_lane (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [qbb_pkg::COORD_WIDTH-1:0] p0,
   input  logic signed [qbb_pkg::COORD_WIDTH-1:0] p1,
   input  logic signed [qbb_pkg::COORD_WIDTH-1:0] p2,
   output qbb_pkg::span_type                      span
);

   typedef struct packed {
      logic signed [qbb_pkg::COORD_WIDTH-1:0] p0;
      logic signed [qbb_pkg::COORD_WIDTH-1:0] lo;
      logic signed [qbb_pkg::COORD_WIDTH-1:0] hi;
      logic signed [qbb_pkg::A_WIDTH-1:0]     a;
      logic signed [qbb_pkg::A_WIDTH-1:0]     n;
      logic        [qbb_pkg::A_WIDTH-1:0]     an;
      logic                                   ok;
   } carry_type;

   // entry stage
   logic signed [qbb_pkg::A_WIDTH-1:0] p0_e, p1_e, p2_e, a_c, n_c;
   logic        [qbb_pkg::A_WIDTH-1:0] nn_c, an_c;
   carry_type                          c0_in;

   // divider stages, index 0 is the entry stage
   carry_type                          dc_ff [qbb_pkg::T_FRAC_BITS+2];
   logic [qbb_pkg::A_WIDTH-1:0]        dr_ff [qbb_pkg::T_FRAC_BITS+2];
   logic [qbb_pkg::TQ_WIDTH-1:0]       dq_ff [qbb_pkg::T_FRAC_BITS+2];
   logic [qbb_pkg::A_WIDTH-1:0]        dr_in [qbb_pkg::T_FRAC_BITS+2];
   logic [qbb_pkg::TQ_WIDTH-1:0]       dq_in [qbb_pkg::T_FRAC_BITS+2];
   logic [qbb_pkg::A_WIDTH-1:0]        r_cur;
   logic [qbb_pkg::A_WIDTH:0]          trial;

   // evaluation stages
   logic signed [qbb_pkg::A_WIDTH+qbb_pkg::TQ_WIDTH:0] at_c;
   logic signed [qbb_pkg::INNER_WIDTH-1:0]              inner_in, inner_ff;
   logic [qbb_pkg::TQ_WIDTH-1:0]                        tq1_ff;
   carry_type                                           m1_ff, m2_ff, m3_ff, m4_ff;
   logic [qbb_pkg::INNER_WIDTH-1:0]                     mag_c;
   logic [qbb_pkg::SPLIT_HI+qbb_pkg::TQ_WIDTH-1:0]      ph_in, ph_ff;
   logic [qbb_pkg::SPLIT_LO+qbb_pkg::TQ_WIDTH-1:0]      pl_in, pl_ff;
   logic                                                neg2_ff, neg3_ff;
   logic [qbb_pkg::PROD_WIDTH-1:0]                      prod_in, prod_ff;
   logic [qbb_pkg::COORD_WIDTH-1:0]                     q_c, qs_c;
   logic                                                nz_c;
   logic signed [qbb_pkg::COORD_WIDTH-1:0]              k_in, k_ff;
   qbb_pkg::span_type                                   span_in, span_ff;

   always_comb begin
      p0_e = qbb_pkg::A_WIDTH'(p0);
      p1_e = qbb_pkg::A_WIDTH'(p1);
      p2_e = qbb_pkg::A_WIDTH'(p2);
      a_c  = p0_e - (p1_e <<< 1) + p2_e;
      n_c  = p0_e - p1_e;
      nn_c = n_c[qbb_pkg::A_WIDTH-1] ? -n_c : n_c;
      an_c = a_c[qbb_pkg::A_WIDTH-1] ? -a_c : a_c;
      c0_in.p0 = p0;
      c0_in.lo = (p0 < p2) ? p0 : p2;
      c0_in.hi = (p0 < p2) ? p2 : p0;
      c0_in.a  = a_c;
      c0_in.n  = n_c;
      c0_in.an = an_c;
      c0_in.ok = (a_c != '0)
               && ((n_c == '0) || (n_c[qbb_pkg::A_WIDTH-1] == a_c[qbb_pkg::A_WIDTH-1]))
               && (nn_c <= an_c);
   end

   // one quotient bit per stage, most significant first
   always_comb begin
      dr_in[0] = nn_c;
      dq_in[0] = '0;
      r_cur    = '0;
      trial    = '0;
      for (int d = 1; d < qbb_pkg::T_FRAC_BITS + 2; d++) begin
         if (d == 1) begin
            r_cur = dr_ff[d-1];
         end else begin
            r_cur = dr_ff[d-1] << 1;
         end
         trial    = {1'b0, r_cur} - {1'b0, dc_ff[d-1].an};
         dr_in[d] = trial[qbb_pkg::A_WIDTH] ? r_cur : trial[qbb_pkg::A_WIDTH-1:0];
         dq_in[d] = {dq_ff[d-1][qbb_pkg::TQ_WIDTH-2:0], ~trial[qbb_pkg::A_WIDTH]};
      end
   end

   always_comb begin
      at_c     = dc_ff[qbb_pkg::T_FRAC_BITS+1].a
               * $signed({1'b0, dq_ff[qbb_pkg::T_FRAC_BITS+1]});
      inner_in = qbb_pkg::INNER_WIDTH'(at_c)
               - (qbb_pkg::INNER_WIDTH'(dc_ff[qbb_pkg::T_FRAC_BITS+1].n)
                  <<< (qbb_pkg::T_FRAC_BITS + 1));

      mag_c = inner_ff[qbb_pkg::INNER_WIDTH-1] ? unsigned'(-inner_ff) : unsigned'(inner_ff);
      ph_in = mag_c[qbb_pkg::INNER_WIDTH-1:qbb_pkg::SPLIT_LO] * tq1_ff;
      pl_in = mag_c[qbb_pkg::SPLIT_LO-1:0] * tq1_ff;

      prod_in = (qbb_pkg::PROD_WIDTH'(ph_ff) << qbb_pkg::SPLIT_LO)
              + qbb_pkg::PROD_WIDTH'(pl_ff);

      // floor of the scaled product, negative side rounds away from zero
      q_c  = prod_ff[2*qbb_pkg::T_FRAC_BITS +: qbb_pkg::COORD_WIDTH];
      nz_c = |prod_ff[2*qbb_pkg::T_FRAC_BITS-1:0];
      qs_c = neg3_ff ? ~q_c : q_c;
      k_in = m3_ff.p0 + $signed(qs_c)
           + $signed(qbb_pkg::COORD_WIDTH'(neg3_ff && !nz_c));

      span_in.mn = (m4_ff.ok && (k_ff < m4_ff.lo)) ? k_ff : m4_ff.lo;
      span_in.mx = (m4_ff.ok && (k_ff > m4_ff.hi)) ? k_ff : m4_ff.hi;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff[0] <= c0_in;
         dr_ff[0] <= dr_in[0];
         dq_ff[0] <= dq_in[0];
         for (int d = 1; d < qbb_pkg::T_FRAC_BITS + 2; d++) begin
            dc_ff[d] <= dc_ff[d-1];
            dr_ff[d] <= dr_in[d];
            dq_ff[d] <= dq_in[d];
         end
         inner_ff <= inner_in;
         tq1_ff   <= dq_ff[qbb_pkg::T_FRAC_BITS+1];
         m1_ff    <= dc_ff[qbb_pkg::T_FRAC_BITS+1];
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
         neg2_ff  <= inner_ff[qbb_pkg::INNER_WIDTH-1];
         m2_ff    <= m1_ff;
         prod_ff  <= prod_in;
         neg3_ff  <= neg2_ff;
         m3_ff    <= m2_ff;
         k_ff     <= k_in;
         m4_ff    <= m3_ff;
         span_ff  <= span_in;
      end
   end

   assign span = span_ff;

endmodule

// ===== rtl/qbb_merge.sv =====
// merge stage: combines the x and y lane spans into the registered box
// depends on qbb_pkg

module qbb_merge (
   input  logic                                   clock,
   input  logic                                   en,
   input  qbb_pkg::span_type                      span_x,
   input  qbb_pkg::span_type                      span_y,
   output logic signed [qbb_pkg::COORD_WIDTH-1:0] box_min_x,
   output logic signed [qbb_pkg::COORD_WIDTH-1:0] box_min_y,
   output logic        [qbb_pkg::COORD_WIDTH-1:0] box_width,
   output logic        [qbb_pkg::COORD_WIDTH-1:0] box_height
);

   logic signed [qbb_pkg::COORD_WIDTH-1:0] min_x_ff, min_y_ff;
   logic        [qbb_pkg::COORD_WIDTH-1:0] width_ff, height_ff, width_in, height_in;

   always_comb begin
      width_in  = unsigned'(span_x.mx - span_x.mn);
      height_in = unsigned'(span_y.mx - span_y.mn);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         min_x_ff  <= span_x.mn;
         min_y_ff  <= span_y.mn;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign box_min_x  = min_x_ff;
   assign box_min_y  = min_y_ff;
   assign box_width  = width_ff;
   assign box_height = height_ff;

endmodule

// ===== rtl/quadratic_bezier_bounding_box.sv =====
// quadratic bezier bounding box, one curve per transfer, one box per curve
// one curve accepted every cycle unless a held response waits for rsp ready
// the depth is set by the per-axis divider pipeline, one quotient bit a stage
// synchronous active-high reset clears the valid flags; data regs hold no reset
// depends on qbb_pkg, qbb_if, qbb_axis_lane, qbb_merge

module quadratic_bezier_bounding_box (
   input logic     clock,
   input logic     reset,
   qbb_req_if.sink   req_ch,
   qbb_rsp_if.source rsp_ch
);

   logic                              advance;
   logic [qbb_pkg::LANE_LATENCY-1:0]  vld_ff, vld_in;
   logic                              rsp_valid_ff;
   qbb_pkg::span_type                 span_x, span_y;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign vld_in       = {vld_ff[qbb_pkg::LANE_LATENCY-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[qbb_pkg::LANE_LATENCY-1];
      end
   end

   qbb_axis_lane u_lane_x (
      .clock (clock),
      .en    (advance),
      .p0    (req_ch.p0_x),
      .p1    (req_ch.p1_x),
      .p2    (req_ch.p2_x),
      .span  (span_x)
   );

   qbb_axis_lane u_lane_y (
      .clock (clock),
      .en    (advance),
      .p0    (req_ch.p0_y),
      .p1    (req_ch.p1_y),
      .p2    (req_ch.p2_y),
      .span  (span_y)
   );

   qbb_merge u_merge (
      .clock      (clock),
      .en         (advance),
      .span_x     (span_x),
      .span_y     (span_y),
      .box_min_x  (rsp_ch.box_min_x),
      .box_min_y  (rsp_ch.box_min_y),
      .box_width  (rsp_ch.box_width),
      .box_height (rsp_ch.box_height)
   );

   assign rsp_ch.valid = rsp_valid_ff;

endmodule
